// ===== sv/sld_pkg.sv =====
// package for the capacitive slider position block
// holds the sequencer state type, register indexes and fixed field widths
// no dependencies
`default_nettype none
package sld_pkg;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int MASK_W = 12;
    localparam int CFG_INDEX_W = 8;

    localparam int FULL_RANGE = 65536;
    localparam logic [VAL_W-1:0] RANGE_EXT_RESET = 16'h0BD0 * 16'd2;
    localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_LINEAR_MODE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_EXT   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_MASK    = 8'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NBR_B,
        ST_NBR_A,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== sv/sld_div.sv =====
// sequential restoring divider, one quotient bit per cycle
// depends on sld_pkg for the operand widths
`default_nettype none
module sld_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sld_pkg::PROD_W-1:0]  i_dividend,
    input  wire logic [sld_pkg::VAL_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [sld_pkg::PROD_W-1:0]       o_quotient
);

    localparam int CntW = $clog2(sld_pkg::PROD_W);

    logic [sld_pkg::VAL_W-1:0]  r_rem, n_rem;
    logic [sld_pkg::PROD_W-1:0] r_quo, n_quo;
    logic [sld_pkg::VAL_W-1:0]  r_dvs;
    logic [CntW-1:0]            r_cnt;
    logic                       r_run;
    logic                       r_done;
    logic [sld_pkg::VAL_W:0]    trial;
    logic                       fits;

    always_comb begin
        trial = {r_rem, r_quo[sld_pkg::PROD_W-1]};
        fits  = trial >= {1'b0, r_dvs};
        if (fits) begin
            n_rem = sld_pkg::VAL_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[sld_pkg::VAL_W-1:0];
        end
        n_quo = {r_quo[sld_pkg::PROD_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(sld_pkg::PROD_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== sv/capacitive_slider_position_top.sv =====
// top level of the capacitive slider position block
// pad store, sequencer and position datapath; uses sld_pkg and sld_div
//
// Items that are not the last pad of a frame are taken into the pad store and
// leave busy low. A last-pad item with no masked touch gives its result on
// o_done in the next cycle. A touched frame keeps busy high through a
// one-port scan of the pad store for the strongest pad, two neighbor reads,
// one multiply, the serial divider and a final step. When linear mode pins
// the position or both neighbors are empty the divider is skipped. Each
// result is shown for a single cycle on o_done and must be taken then;
// configuration is accepted only while the block is idle.
`default_nettype none
module capacitive_slider_position_top #(
    parameter int PAD_COUNT = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [15:0]                      i_conv_value,
    input  wire logic [15:0]                      i_ambient_value,
    input  wire logic [11:0]                      i_touch_status,
    input  wire logic                             i_last_pad,
    output logic                                  o_done,
    output logic                                  o_touched,
    output logic [15:0]                           o_position,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [sld_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [15:0]                      i_cfg_data
);

    localparam int AW = $clog2(PAD_COUNT);
    localparam int IW = $clog2(PAD_COUNT + 1);
    localparam logic [16:0] PadRange = 17'(sld_pkg::FULL_RANGE / PAD_COUNT + 1);
    localparam logic [15:0] HalfRange = 16'(PadRange / 2);

    sld_pkg::t_state r_state, n_state;

    logic        r_linear;
    logic [15:0] r_rext;
    logic [11:0] r_mask;

    logic [15:0] mem [PAD_COUNT];
    logic [15:0] r_rdata;
    logic [AW-1:0] rd_addr;

    logic [IW-1:0] r_pidx;
    logic [IW-1:0] r_cnt;
    logic          r_rv;
    logic [AW-1:0] r_ridx;
    logic [15:0]   r_max;
    logic [AW-1:0] r_h;
    logic [15:0]   r_vb;
    logic          r_up;
    logic [31:0]   r_prod;
    logic [15:0]   r_big;
    logic [15:0]   r_base;
    logic [15:0]   r_off;
    logic          r_div_go;

    logic          r_done;
    logic          r_touched;
    logic [15:0]   r_pos;

    logic          accept;
    logic          touch_hit;
    logic [15:0]   pad_val;
    logic [AW-1:0] idx_b, idx_a;
    logic          issue;
    logic          take;
    logic          va_gt;
    logic [15:0]   big, diff;
    logic          skip_div;
    logic          div_done;
    logic [31:0]   quo;

    assign accept    = i_start && !o_busy;
    assign touch_hit = (i_touch_status & r_mask) != '0;
    assign pad_val   = (i_conv_value > i_ambient_value) ? i_conv_value - i_ambient_value : '0;
    assign idx_b = (r_h == '0) ? AW'(PAD_COUNT - 1) : r_h - 1'b1;
    assign idx_a = (r_h == AW'(PAD_COUNT - 1)) ? '0 : r_h + 1'b1;
    assign issue = (r_state == sld_pkg::ST_SCAN) && (r_cnt < IW'(PAD_COUNT));
    assign take  = r_rv && ((r_ridx == '0) || (r_rdata > r_max));
    assign va_gt = r_rdata > r_vb;
    assign big   = va_gt ? r_rdata : r_vb;
    assign diff  = va_gt ? r_rdata - r_vb : r_vb - r_rdata;
    assign skip_div = (r_linear && r_h == '0) || (big == '0);

    always_comb begin
        unique case (r_state)
            sld_pkg::ST_NBR_B: rd_addr = idx_b;
            sld_pkg::ST_NBR_A: rd_addr = idx_a;
            default:           rd_addr = r_cnt[AW-1:0];
        endcase
    end

    // config registers
    assign o_cfg_ready = !o_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear <= 1'b0;
            r_rext   <= sld_pkg::RANGE_EXT_RESET;
            r_mask   <= sld_pkg::MASK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sld_pkg::REG_LINEAR_MODE: r_linear <= i_cfg_data[0];
                sld_pkg::REG_RANGE_EXT:   r_rext   <= i_cfg_data;
                sld_pkg::REG_PAD_MASK:    r_mask   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // pad store
    always_ff @(posedge i_clk) begin
        if (accept && r_pidx < IW'(PAD_COUNT)) begin
            mem[r_pidx[AW-1:0]] <= pad_val;
        end
        r_rdata <= mem[rd_addr];
    end

    sld_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_prod),
        .i_divisor  (r_big),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sld_pkg::ST_IDLE: begin
                if (accept && i_last_pad && touch_hit) begin
                    n_state = sld_pkg::ST_SCAN;
                end
            end
            sld_pkg::ST_SCAN: begin
                if (r_rv && r_ridx == AW'(PAD_COUNT - 1)) begin
                    n_state = sld_pkg::ST_NBR_B;
                end
            end
            sld_pkg::ST_NBR_B: n_state = sld_pkg::ST_NBR_A;
            sld_pkg::ST_NBR_A: n_state = sld_pkg::ST_MUL;
            sld_pkg::ST_MUL: begin
                n_state = skip_div ? sld_pkg::ST_FIN : sld_pkg::ST_DIV;
            end
            sld_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = sld_pkg::ST_FIN;
                end
            end
            sld_pkg::ST_FIN: n_state = sld_pkg::ST_IDLE;
            default:         n_state = sld_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sld_pkg::ST_IDLE;
            r_pidx   <= '0;
            r_done   <= 1'b0;
            r_rv     <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= 1'b0;
            r_div_go <= 1'b0;
            r_rv     <= issue;
            if (accept) begin
                if (i_last_pad) begin
                    r_pidx <= '0;
                    if (!touch_hit) begin
                        r_done <= 1'b1;
                    end
                end else if (r_pidx < IW'(PAD_COUNT)) begin
                    r_pidx <= r_pidx + 1'b1;
                end
            end
            if (r_state == sld_pkg::ST_MUL && !skip_div) begin
                r_div_go <= 1'b1;
            end
            if (r_state == sld_pkg::ST_FIN) begin
                r_done <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sld_pkg::ST_IDLE: begin
                r_cnt <= '0;
                if (accept && i_last_pad) begin
                    r_touched <= touch_hit;
                    r_pos     <= '0;
                end
            end
            sld_pkg::ST_SCAN: begin
                if (issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_ridx <= r_cnt[AW-1:0];
                if (take) begin
                    r_max <= r_rdata;
                    r_h   <= r_ridx;
                end
            end
            sld_pkg::ST_NBR_B: ;
            sld_pkg::ST_NBR_A: r_vb <= r_rdata;
            sld_pkg::ST_MUL: begin
                r_up   <= va_gt;
                r_prod <= 32'(diff) * 32'(r_rext);
                r_big  <= big;
                r_base <= 16'(21'(r_h) * 21'(PadRange));
                r_off  <= '0;
            end
            sld_pkg::ST_DIV: begin
                if (div_done) begin
                    r_off <= (quo > 32'(HalfRange)) ? HalfRange : quo[15:0];
                end
            end
            sld_pkg::ST_FIN: begin
                if (r_linear && r_h == '0) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_up ? r_base + r_off : r_base - r_off;
                end
            end
            default: ;
        endcase
    end

    assign o_busy     = r_state != sld_pkg::ST_IDLE;
    assign o_done     = r_done;
    assign o_touched  = r_touched;
    assign o_position = r_pos;

endmodule
`default_nettype wire
